/* design/pbms_pkg.sv */
// ----------------------------------------------------------------------------
// pbms_pkg: shared types and constants for the pose bucket selector
// Holds the stored pose layout, the controller/datapath command and status
// records, register indexes, weight reset values and the distance helper.
// ----------------------------------------------------------------------------
package pbms_pkg;

    // Fixed widths that follow from the field formats or from the largest
    // allowed slots-per-cell value (8).
    localparam int CNT_W     = 4;   // fill count 0..8
    localparam int SLOT_W    = 3;   // slot index 0..7
    localparam int W_W       = 12;  // Q4.8 weight
    localparam int CFG_IDX_W = 3;
    localparam int ABS_W     = 9;   // largest angle distance is 511
    localparam int PROD_W    = 21;  // 12 x 9 bits
    localparam int COST_W    = 24;  // five products
    localparam int NUM_ANG   = 5;
    localparam int POSE_W    = 31;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_YAW         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_JOINT_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_JOINT_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_JOINT_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_WRIST       = 3'd4;

    // Weight reset values: 1.0, 1.0, 0.5, 0.1, 0.01 in Q4.8
    localparam logic [W_W-1:0] RST_WEIGHT_YAW         = 12'd256;
    localparam logic [W_W-1:0] RST_WEIGHT_JOINT_ONE   = 12'd256;
    localparam logic [W_W-1:0] RST_WEIGHT_JOINT_TWO   = 12'd128;
    localparam logic [W_W-1:0] RST_WEIGHT_JOINT_THREE = 12'd26;
    localparam logic [W_W-1:0] RST_WEIGHT_WRIST       = 12'd3;

    typedef struct packed {
        logic signed [8:0] yaw;
        logic signed [6:0] joint_one;
        logic signed [6:0] joint_two;
        logic signed [6:0] joint_three;
        logic              wrist;
    } pose_t;

    typedef struct packed {
        logic              load_req;    // capture the accepted item
        logic              clear_step;  // write one zero count, advance sweep
        logic              cnt_wr;      // store the set and bump the count
        logic              scan_issue;  // read one stored set
        logic              scan_first;  // the issued set is slot zero
        logic [SLOT_W-1:0] slot_idx;
        logic              out_load;    // load the result register
        logic              out_ok;
        logic              out_best;    // drive the best set, else zeros
    } cmd_t;

    typedef struct packed {
        logic             on_grid;
        logic             is_query;
        logic [CNT_W-1:0] fill_cnt;
        logic             clear_last;
    } status_t;

    // Absolute difference of two sign-extended angles
    function automatic logic [ABS_W-1:0] abs_diff(input logic signed [9:0] p,
                                                  input logic signed [9:0] q);
        logic signed [10:0] d;
        d = {p[9], p} - {q[9], q};
        return d[10] ? ABS_W'(-d) : ABS_W'(d);
    endfunction

endpackage

/* design/pose_bucket_min_move_select.sv */
// ----------------------------------------------------------------------------
// pose_bucket_min_move_select: grid of pose buckets with least-move lookup
// Stores up to SLOTS_PER_CELL joint-angle sets per grid cell and answers
// queries with the stored set of least weighted movement from the present
// angles.
// ----------------------------------------------------------------------------
// The block takes one item at a time. An insert goes from acceptance to
// result through capture, count lookup in the count RAM, store and count
// update, and result load. A query that finds n stored sets reads them
// after the count lookup: the slot RAM delivers one stored set per cycle
// into a three-stage cost pipeline (read, five weighted products, sum and
// compare), which drains through S_DRAIN1 and S_DRAIN2 after the last
// read. Queries on an empty cell skip the scan, and items whose cell lies
// off the grid skip the count check as well. The result sits in an output
// register, so the next item is accepted while the previous result waits
// to be taken. After reset the block sweeps all GRID_SIZE^3 cells of the
// count RAM to zero and holds s_ready low until the sweep ends;
// configuration writes are taken at any time. Weights are Q4.8; the cost is
// exact and ties keep the earliest stored set.
// ----------------------------------------------------------------------------
module pose_bucket_min_move_select #(
    parameter int GRID_SIZE      = 7,
    parameter int SLOTS_PER_CELL = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [pbms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbms_pkg::W_W-1:0]       cfg_wdata,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic signed [2:0]              s_cell_x,
    input  logic signed [2:0]              s_cell_y,
    input  logic signed [2:0]              s_cell_z,
    input  logic signed [8:0]              s_yaw_angle,
    input  logic signed [6:0]              s_joint_one_angle,
    input  logic signed [6:0]              s_joint_two_angle,
    input  logic signed [6:0]              s_joint_three_angle,
    input  logic                           s_wrist_angle,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ok,
    output logic signed [8:0]              m_best_yaw,
    output logic signed [6:0]              m_best_joint_one,
    output logic signed [6:0]              m_best_joint_two,
    output logic signed [6:0]              m_best_joint_three,
    output logic                           m_best_wrist
);
    import pbms_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence each item: clear sweep, capture, count lookup, scan, hand off.
    pbms_ctrl #(
        .SLOTS_PER_CELL(SLOTS_PER_CELL)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the item, weights and stores; compute costs and drive the result.
    pbms_dp #(
        .GRID_SIZE      (GRID_SIZE),
        .SLOTS_PER_CELL (SLOTS_PER_CELL)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_req_type          (s_req_type),
        .s_cell_x            (s_cell_x),
        .s_cell_y            (s_cell_y),
        .s_cell_z            (s_cell_z),
        .s_yaw_angle         (s_yaw_angle),
        .s_joint_one_angle   (s_joint_one_angle),
        .s_joint_two_angle   (s_joint_two_angle),
        .s_joint_three_angle (s_joint_three_angle),
        .s_wrist_angle       (s_wrist_angle),
        .m_ok                (m_ok),
        .m_best_yaw          (m_best_yaw),
        .m_best_joint_one    (m_best_joint_one),
        .m_best_joint_two    (m_best_joint_two),
        .m_best_joint_three  (m_best_joint_three),
        .m_best_wrist        (m_best_wrist)
    );

endmodule

/* design/pbms_ram.sv */
// ----------------------------------------------------------------------------
// pbms_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/pbms_ctrl.sv */
// ----------------------------------------------------------------------------
// pbms_ctrl: sequencer of the pose bucket selector
// Runs the count clearing sweep, item capture, count lookup, slot scan and
// result hand-off; owns the result valid flag.
// ----------------------------------------------------------------------------
module pbms_ctrl #(
    parameter int SLOTS_PER_CELL = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pbms_pkg::status_t status,
    output pbms_pkg::cmd_t    cmd
);
    import pbms_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RDCNT  = 3'd2;
    localparam logic [2:0] S_CNT    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DRAIN1 = 3'd5;
    localparam logic [2:0] S_DRAIN2 = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOTS_PER_CELL);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              res_ok_reg, res_ok_next;
    logic              res_best_reg, res_best_next;
    logic              m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]  n_clamp;

    assign n_clamp = (status.fill_cnt > SLOTS) ? SLOTS : status.fill_cnt;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        res_ok_next   = res_ok_reg;
        res_best_next = res_best_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_RDCNT;
                end
            end
            S_RDCNT: begin
                if (!status.on_grid) begin
                    res_ok_next   = 1'b0;
                    res_best_next = 1'b0;
                    state_next    = S_DONE;
                end else begin
                    state_next = S_CNT;
                end
            end
            S_CNT: begin
                if (!status.is_query) begin
                    res_best_next = 1'b0;
                    res_ok_next   = (status.fill_cnt < SLOTS);
                    cmd.cnt_wr    = (status.fill_cnt < SLOTS);
                    state_next    = S_DONE;
                end else if (n_clamp == '0) begin
                    res_ok_next   = 1'b0;
                    res_best_next = 1'b0;
                    state_next    = S_DONE;
                end else begin
                    n_next        = n_clamp;
                    idx_next      = '0;
                    res_ok_next   = 1'b1;
                    res_best_next = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                cmd.scan_first = (idx_reg == '0);
                cmd.slot_idx   = idx_reg;
                if (CNT_W'(idx_reg) + CNT_W'(1) == n_reg) begin
                    state_next = S_DRAIN1;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_DRAIN1: begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = res_ok_reg;
                    cmd.out_best = res_best_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            n_reg        <= '0;
            idx_reg      <= '0;
            res_ok_reg   <= 1'b0;
            res_best_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            idx_reg      <= idx_next;
            res_ok_reg   <= res_ok_next;
            res_best_reg <= res_best_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

/* design/pbms_dp.sv */
// ----------------------------------------------------------------------------
// pbms_dp: datapath of the pose bucket selector
// Item and weight registers, cell addressing, count and slot RAMs, the
// three-stage cost pipeline with running minimum, and the result register.
// ----------------------------------------------------------------------------
module pbms_dp #(
    parameter int GRID_SIZE      = 7,
    parameter int SLOTS_PER_CELL = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pbms_pkg::cmd_t                cmd,
    output pbms_pkg::status_t             status,
    input  logic                          cfg_wr_en,
    input  logic [pbms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbms_pkg::W_W-1:0]      cfg_wdata,
    input  logic                          s_req_type,
    input  logic signed [2:0]             s_cell_x,
    input  logic signed [2:0]             s_cell_y,
    input  logic signed [2:0]             s_cell_z,
    input  logic signed [8:0]             s_yaw_angle,
    input  logic signed [6:0]             s_joint_one_angle,
    input  logic signed [6:0]             s_joint_two_angle,
    input  logic signed [6:0]             s_joint_three_angle,
    input  logic                          s_wrist_angle,
    output logic                          m_ok,
    output logic signed [8:0]             m_best_yaw,
    output logic signed [6:0]             m_best_joint_one,
    output logic signed [6:0]             m_best_joint_two,
    output logic signed [6:0]             m_best_joint_three,
    output logic                          m_best_wrist
);
    import pbms_pkg::*;

    localparam int CELLS   = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int SLOT_AW = $clog2(CELLS * SLOTS_PER_CELL);
    localparam int AXW     = $clog2(GRID_SIZE);
    localparam int HALF    = GRID_SIZE / 2;

    // ---- weights
    logic [W_W-1:0] w_yaw_reg, w_j1_reg, w_j2_reg, w_j3_reg, w_wr_reg;
    logic [W_W-1:0] wts [NUM_ANG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_yaw_reg <= RST_WEIGHT_YAW;
            w_j1_reg  <= RST_WEIGHT_JOINT_ONE;
            w_j2_reg  <= RST_WEIGHT_JOINT_TWO;
            w_j3_reg  <= RST_WEIGHT_JOINT_THREE;
            w_wr_reg  <= RST_WEIGHT_WRIST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WEIGHT_YAW:         w_yaw_reg <= cfg_wdata;
                REG_WEIGHT_JOINT_ONE:   w_j1_reg  <= cfg_wdata;
                REG_WEIGHT_JOINT_TWO:   w_j2_reg  <= cfg_wdata;
                REG_WEIGHT_JOINT_THREE: w_j3_reg  <= cfg_wdata;
                REG_WEIGHT_WRIST:       w_wr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign wts[0] = w_yaw_reg;
    assign wts[1] = w_j1_reg;
    assign wts[2] = w_j2_reg;
    assign wts[3] = w_j3_reg;
    assign wts[4] = w_wr_reg;

    // ---- cell addressing
    logic signed [4:0]  ax, ay, az;
    logic               on_grid;
    logic [CELL_AW-1:0] cell_idx;

    assign ax = {{2{s_cell_x[2]}}, s_cell_x} + 5'(HALF);
    assign ay = {{2{s_cell_y[2]}}, s_cell_y} + 5'(HALF);
    assign az = {{2{s_cell_z[2]}}, s_cell_z} + 5'(HALF);

    assign on_grid = !ax[4] && (ax[3:0] < 4'(GRID_SIZE)) &&
                     !ay[4] && (ay[3:0] < 4'(GRID_SIZE)) &&
                     !az[4] && (az[3:0] < 4'(GRID_SIZE));

    assign cell_idx = (CELL_AW'(ax[AXW-1:0]) * CELL_AW'(GRID_SIZE) +
                       CELL_AW'(ay[AXW-1:0])) * CELL_AW'(GRID_SIZE) +
                      CELL_AW'(az[AXW-1:0]);

    // ---- captured item
    logic               is_query_reg;
    logic               on_grid_reg;
    logic [CELL_AW-1:0] cell_reg;
    logic [SLOT_AW-1:0] base_reg;
    pose_t              req_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            is_query_reg        <= s_req_type;
            on_grid_reg         <= on_grid;
            cell_reg            <= cell_idx;
            req_reg.yaw         <= s_yaw_angle;
            req_reg.joint_one   <= s_joint_one_angle;
            req_reg.joint_two   <= s_joint_two_angle;
            req_reg.joint_three <= s_joint_three_angle;
            req_reg.wrist       <= s_wrist_angle;
        end
        base_reg <= SLOT_AW'(SLOT_AW'(cell_reg) * SLOT_AW'(SLOTS_PER_CELL));
    end

    // ---- count RAM and its clearing sweep
    logic [CELL_AW-1:0] clr_reg;
    logic [CNT_W-1:0]   fill_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_reg <= clr_reg + CELL_AW'(1);
        end
    end

    pbms_ram #(
        .WIDTH(CNT_W),
        .DEPTH(CELLS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cmd.clear_step | cmd.cnt_wr),
        .waddr (cmd.clear_step ? clr_reg : cell_reg),
        .wdata (cmd.clear_step ? CNT_W'(0) : fill_cnt + CNT_W'(1)),
        .raddr (cell_reg),
        .rdata (fill_cnt)
    );

    assign status.on_grid    = on_grid_reg;
    assign status.is_query   = is_query_reg;
    assign status.fill_cnt   = fill_cnt;
    assign status.clear_last = (clr_reg == CELL_AW'(CELLS - 1));

    // ---- slot RAM
    logic [POSE_W-1:0] slot_rd;

    pbms_ram #(
        .WIDTH(POSE_W),
        .DEPTH(CELLS * SLOTS_PER_CELL)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (cmd.cnt_wr),
        .waddr (base_reg + SLOT_AW'(fill_cnt[SLOT_W-1:0])),
        .wdata (req_reg),
        .raddr (base_reg + SLOT_AW'(cmd.slot_idx)),
        .rdata (slot_rd)
    );

    // ---- cost pipeline: RAM read, products, sum and compare
    logic              v1_reg, f1_reg, v2_reg, f2_reg;
    pose_t             ent1, ent2_reg, best_reg;
    logic [ABS_W-1:0]  ang_gap [NUM_ANG];
    logic [PROD_W-1:0] prod_reg [NUM_ANG];
    logic [COST_W-1:0] cost, best_cost_reg;

    assign ent1 = pose_t'(slot_rd);

    always_comb begin
        ang_gap[0] = abs_diff({ent1.yaw[8], ent1.yaw}, {req_reg.yaw[8], req_reg.yaw});
        ang_gap[1] = abs_diff({{3{ent1.joint_one[6]}}, ent1.joint_one},
                              {{3{req_reg.joint_one[6]}}, req_reg.joint_one});
        ang_gap[2] = abs_diff({{3{ent1.joint_two[6]}}, ent1.joint_two},
                              {{3{req_reg.joint_two[6]}}, req_reg.joint_two});
        ang_gap[3] = abs_diff({{3{ent1.joint_three[6]}}, ent1.joint_three},
                              {{3{req_reg.joint_three[6]}}, req_reg.joint_three});
        ang_gap[4] = abs_diff({9'b0, ent1.wrist}, {9'b0, req_reg.wrist});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_reg   <= cmd.scan_first;
        f2_reg   <= f1_reg;
        ent2_reg <= ent1;
        for (int k = 0; k < NUM_ANG; k++) begin
            prod_reg[k] <= PROD_W'(wts[k]) * PROD_W'(ang_gap[k]);
        end
    end

    assign cost = COST_W'(prod_reg[0]) + COST_W'(prod_reg[1]) + COST_W'(prod_reg[2]) +
                  COST_W'(prod_reg[3]) + COST_W'(prod_reg[4]);

    // Keep the earliest set on a tie: replace only on a strictly lower cost.
    always_ff @(posedge aclk) begin
        if (v2_reg && (f2_reg || cost < best_cost_reg)) begin
            best_cost_reg <= cost;
            best_reg      <= ent2_reg;
        end
    end

    // ---- result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_ok               <= cmd.out_ok;
            m_best_yaw         <= cmd.out_best ? best_reg.yaw         : 9'sd0;
            m_best_joint_one   <= cmd.out_best ? best_reg.joint_one   : 7'sd0;
            m_best_joint_two   <= cmd.out_best ? best_reg.joint_two   : 7'sd0;
            m_best_joint_three <= cmd.out_best ? best_reg.joint_three : 7'sd0;
            m_best_wrist       <= cmd.out_best ? best_reg.wrist       : 1'b0;
        end
    end

endmodule

/* design/pbms_chk.sv */
// ----------------------------------------------------------------------------
// pbms_chk: port-level checks for the pose bucket selector
// Watches the top-level ports over time; attached by the bind below.
// ----------------------------------------------------------------------------
module pbms_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_ok,
    input logic signed [8:0] m_best_yaw,
    input logic signed [6:0] m_best_joint_one,
    input logic signed [6:0] m_best_joint_two,
    input logic signed [6:0] m_best_joint_three,
    input logic              m_best_wrist
);

    // The clearing sweep follows reset: no item is taken right after it.
    a_no_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high in the cycle after reset");

    // One item at a time: s_ready drops once an item is accepted.
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted back to back");

    // A failed insert or an empty query returns all-zero angles.
    a_zero_when_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_best_yaw == 9'sd0 && m_best_joint_one == 7'sd0 &&
                                m_best_joint_two == 7'sd0 &&
                                m_best_joint_three == 7'sd0 && !m_best_wrist))
        else $error("nonzero angles on a result without ok");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_ok) && $stable(m_best_yaw) &&
                                   $stable(m_best_joint_one) &&
                                   $stable(m_best_joint_two) &&
                                   $stable(m_best_joint_three) &&
                                   $stable(m_best_wrist)))
        else $error("stalled result changed");

endmodule

bind pose_bucket_min_move_select pbms_chk u_pbms_chk (.*);

/* sim/pose_bucket_min_move_select_tb.sv */
// ----------------------------------------------------------------------------
// pose_bucket_min_move_select_tb: self-checking bench for the pose bucket grid
// Sends insert and query items through the request channel under several
// weight settings and idle patterns. A behavioral copy of the grid predicts
// each result, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module pose_bucket_min_move_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbms_pkg::*;

    localparam int GRID          = 7;
    localparam int GRID_HALF     = GRID / 2;
    localparam int SLOTS         = 6;
    localparam int CELLS         = GRID * GRID * GRID;
    localparam int HOT_CELLS     = 6;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_OFF_LEN  = 300;   // long receiver hold-off, in cycles
    localparam int QUIET_CYCLES  = 20;    // settle time at the end of wait_quiet, in cycles
    localparam int STALL_LIMIT   = 3000;  // cycles with no item moved on either side
    localparam int MAX_REPORTS   = 100;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic signed [2:0] cell_x;
        logic signed [2:0] cell_y;
        logic signed [2:0] cell_z;
        pose_t             pose;
        logic              drain_first;  // hold until every result is back
    } request_t;

    typedef struct packed {
        logic  ok;
        pose_t best;
    } answer_t;

    // Block ports; every input is known from time zero
    logic                 aclk                = 1'b0;
    logic                 aresetn             = 1'b0;
    logic                 cfg_wr_en           = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index           = '0;
    logic [W_W-1:0]       cfg_wdata           = '0;
    logic                 s_valid             = 1'b0;
    logic                 s_ready;
    logic                 s_req_type          = 1'b0;
    logic signed [2:0]    s_cell_x            = '0;
    logic signed [2:0]    s_cell_y            = '0;
    logic signed [2:0]    s_cell_z            = '0;
    logic signed [8:0]    s_yaw_angle         = '0;
    logic signed [6:0]    s_joint_one_angle   = '0;
    logic signed [6:0]    s_joint_two_angle   = '0;
    logic signed [6:0]    s_joint_three_angle = '0;
    logic                 s_wrist_angle       = 1'b0;
    logic                 m_valid;
    logic                 m_ready             = 1'b0;
    logic                 m_ok;
    logic signed [8:0]    m_best_yaw;
    logic signed [6:0]    m_best_joint_one;
    logic signed [6:0]    m_best_joint_two;
    logic signed [6:0]    m_best_joint_three;
    logic                 m_best_wrist;

    // Predictor state: weights, fill level and stored sets of every cell
    logic [W_W-1:0] weight_q48 [NUM_ANG] = '{RST_WEIGHT_YAW, RST_WEIGHT_JOINT_ONE,
                                             RST_WEIGHT_JOINT_TWO, RST_WEIGHT_JOINT_THREE,
                                             RST_WEIGHT_WRIST};
    int    fill_level  [CELLS];
    pose_t stored_sets [CELLS * SLOTS];

    request_t pending_requests [$];
    answer_t  expected_answers [$];

    request_t next_req;
    request_t taken_req;
    answer_t  want;
    logic     req_taken         = 1'b0;
    int       sender_idle_pct   = 0;
    int       recv_stall_pct    = 0;
    int       hold_off_requests = 0;
    int       hold_off_served   = 0;
    int       hold_off_left     = 0;
    int       idle_cycles       = 0;
    int       mismatch_count    = 0;

    pose_bucket_min_move_select #(
        .GRID_SIZE      (GRID),
        .SLOTS_PER_CELL (SLOTS)
    ) u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_cell_x            (s_cell_x),
        .s_cell_y            (s_cell_y),
        .s_cell_z            (s_cell_z),
        .s_yaw_angle         (s_yaw_angle),
        .s_joint_one_angle   (s_joint_one_angle),
        .s_joint_two_angle   (s_joint_two_angle),
        .s_joint_three_angle (s_joint_three_angle),
        .s_wrist_angle       (s_wrist_angle),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_ok                (m_ok),
        .m_best_yaw          (m_best_yaw),
        .m_best_joint_one    (m_best_joint_one),
        .m_best_joint_two    (m_best_joint_two),
        .m_best_joint_three  (m_best_joint_three),
        .m_best_wrist        (m_best_wrist)
    );

    always #1 aclk = ~aclk;

    function automatic int angle_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Apply one accepted item to the grid copy and return the result it gives.
    // Off-grid cells answer zero; a query takes the first set of least cost.
    function automatic answer_t predict_answer(input request_t r);
        answer_t ans;
        int      ix, iy, iz, cell_id, n, pick;
        longint  cost, best_cost;
        pose_t   cand;
        ans       = '0;
        pick      = 0;
        best_cost = 0;
        ix = $signed(r.cell_x) + GRID_HALF;
        iy = $signed(r.cell_y) + GRID_HALF;
        iz = $signed(r.cell_z) + GRID_HALF;
        if (ix < 0 || ix >= GRID || iy < 0 || iy >= GRID || iz < 0 || iz >= GRID)
            return ans;
        cell_id = (ix * GRID + iy) * GRID + iz;
        n       = fill_level[cell_id];
        if (r.req_type == REQ_INSERT) begin
            if (n < SLOTS) begin
                stored_sets[cell_id * SLOTS + n] = r.pose;
                fill_level[cell_id] = n + 1;
                ans.ok = 1'b1;
            end
            return ans;
        end
        if (n == 0)
            return ans;
        for (int s = 0; s < n; s++) begin
            cand = stored_sets[cell_id * SLOTS + s];
            cost = weight_q48[REG_WEIGHT_YAW] *
                       angle_gap($signed(cand.yaw), $signed(r.pose.yaw))
                 + weight_q48[REG_WEIGHT_JOINT_ONE] *
                       angle_gap($signed(cand.joint_one), $signed(r.pose.joint_one))
                 + weight_q48[REG_WEIGHT_JOINT_TWO] *
                       angle_gap($signed(cand.joint_two), $signed(r.pose.joint_two))
                 + weight_q48[REG_WEIGHT_JOINT_THREE] *
                       angle_gap($signed(cand.joint_three), $signed(r.pose.joint_three))
                 + weight_q48[REG_WEIGHT_WRIST] *
                       angle_gap(int'(cand.wrist), int'(r.pose.wrist));
            if (s == 0 || cost < best_cost) begin
                best_cost = cost;
                pick      = s;
            end
        end
        ans.ok   = 1'b1;
        ans.best = stored_sets[cell_id * SLOTS + pick];
        return ans;
    endfunction

    function automatic request_t make_req(input logic kind, input int x, input int y,
                                          input int z, input int yaw, input int j1,
                                          input int j2, input int j3, input int wr);
        request_t r;
        r                  = '0;
        r.req_type         = kind;
        r.cell_x           = 3'(x);
        r.cell_y           = 3'(y);
        r.cell_z           = 3'(z);
        r.pose.yaw         = 9'(yaw);
        r.pose.joint_one   = 7'(j1);
        r.pose.joint_two   = 7'(j2);
        r.pose.joint_three = 7'(j3);
        r.pose.wrist       = 1'(wr);
        return r;
    endfunction

    // Append one item to the sender's queue
    function automatic void queue_req(input request_t r);
        pending_requests = {pending_requests, r};
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] exp_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: got %0d, want %0d at %0t", what, got, exp_val, $time);
    endtask

    // Write one register; only the five weight indexes land in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= REG_WEIGHT_WRIST)
            weight_q48[idx] = val;
    endtask

    // Load all five weights, then hit the unmapped indexes with noise
    task automatic load_weights(input logic [W_W-1:0] w_yaw, input logic [W_W-1:0] w_one,
                                input logic [W_W-1:0] w_two, input logic [W_W-1:0] w_three,
                                input logic [W_W-1:0] w_wrist);
        write_reg(REG_WEIGHT_YAW, w_yaw);
        write_reg(REG_WEIGHT_JOINT_ONE, w_one);
        write_reg(REG_WEIGHT_JOINT_TWO, w_two);
        write_reg(REG_WEIGHT_JOINT_THREE, w_three);
        write_reg(REG_WEIGHT_WRIST, w_wrist);
        for (int i = REG_WEIGHT_WRIST + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), W_W'($urandom));
    endtask

    // Wait until nothing is queued, offered or outstanding, then let the
    // pipeline settle before touching registers again
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || s_valid || expected_answers.size() != 0)
            @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    // Queue one batch of random items. Most land in a few hot cells so they fill
    // up and queries scan full buckets; the rest spread over the grid or fall off it.
    task automatic queue_random_items(input int count);
        int          hot_x [HOT_CELLS];
        int          hot_y [HOT_CELLS];
        int          hot_z [HOT_CELLS];
        int          roll, h, v;
        request_t    r;
        for (int i = 0; i < HOT_CELLS; i++) begin
            hot_x[i] = int'($urandom_range(2 * GRID_HALF)) - GRID_HALF;
            hot_y[i] = int'($urandom_range(2 * GRID_HALF)) - GRID_HALF;
            hot_z[i] = int'($urandom_range(2 * GRID_HALF)) - GRID_HALF;
        end
        for (int i = 0; i < count; i++) begin
            r          = '0;
            r.req_type = ($urandom_range(99) < 40) ? REQ_INSERT : REQ_QUERY;
            roll       = $urandom_range(99);
            if (roll < 70) begin
                h        = $urandom_range(HOT_CELLS - 1);
                r.cell_x = 3'(hot_x[h]);
                r.cell_y = 3'(hot_y[h]);
                r.cell_z = 3'(hot_z[h]);
            end else if (roll < 90) begin
                r.cell_x = 3'(int'($urandom_range(2 * GRID_HALF)) - GRID_HALF);
                r.cell_y = 3'(int'($urandom_range(2 * GRID_HALF)) - GRID_HALF);
                r.cell_z = 3'(int'($urandom_range(2 * GRID_HALF)) - GRID_HALF);
            end else begin
                // any code, including the one coordinate off the grid
                r.cell_x = 3'($urandom);
                r.cell_y = 3'($urandom);
                r.cell_z = 3'($urandom);
            end
            if ($urandom_range(99) < 85) begin
                v = int'($urandom_range(359)) - 179;
                r.pose.yaw = 9'(v);
                v = int'($urandom_range(90)) - 45;
                r.pose.joint_one = 7'(v);
                v = int'($urandom_range(90)) - 45;
                r.pose.joint_two = 7'(v);
                v = int'($urandom_range(90)) - 45;
                r.pose.joint_three = 7'(v);
                r.pose.wrist = 1'($urandom_range(1));
            end else begin
                r.pose = POSE_W'($urandom);
            end
            r.drain_first = (i == count / 2);
            queue_req(r);
        end
    endtask

    // Sender: hold the offered item until it is taken, then offer the next one
    // or go idle. An item marked drain_first waits for every result to return.
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !req_taken)) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                (!pending_requests[0].drain_first || expected_answers.size() == 0)) begin
                next_req            = pending_requests.pop_front();
                s_valid             <= 1'b1;
                s_req_type          <= next_req.req_type;
                s_cell_x            <= next_req.cell_x;
                s_cell_y            <= next_req.cell_y;
                s_cell_z            <= next_req.cell_z;
                s_yaw_angle         <= next_req.pose.yaw;
                s_joint_one_angle   <= next_req.pose.joint_one;
                s_joint_two_angle   <= next_req.pose.joint_two;
                s_joint_three_angle <= next_req.pose.joint_three;
                s_wrist_angle       <= next_req.pose.wrist;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            m_ready       <= 1'b0;
        end else if (hold_off_served != hold_off_requests) begin
            hold_off_served <= hold_off_served + 1;
            hold_off_left   <= HOLD_OFF_LEN;
            m_ready         <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on every accepted item, check every accepted result,
    // and end the run if nothing moves for too long
    always @(posedge aclk) begin
        req_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken_req                  = '0;
                taken_req.req_type         = s_req_type;
                taken_req.cell_x           = s_cell_x;
                taken_req.cell_y           = s_cell_y;
                taken_req.cell_z           = s_cell_z;
                taken_req.pose.yaw         = s_yaw_angle;
                taken_req.pose.joint_one   = s_joint_one_angle;
                taken_req.pose.joint_two   = s_joint_two_angle;
                taken_req.pose.joint_three = s_joint_three_angle;
                taken_req.pose.wrist       = s_wrist_angle;
                expected_answers = {expected_answers, predict_answer(taken_req)};
            end
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("result with nothing pending", m_ok, 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_ok !== want.ok)
                        report_mismatch("ok", m_ok, want.ok);
                    if (m_best_yaw !== want.best.yaw)
                        report_mismatch("best_yaw", m_best_yaw, want.best.yaw);
                    if (m_best_joint_one !== want.best.joint_one)
                        report_mismatch("best_joint_one", m_best_joint_one,
                                        want.best.joint_one);
                    if (m_best_joint_two !== want.best.joint_two)
                        report_mismatch("best_joint_two", m_best_joint_two,
                                        want.best.joint_two);
                    if (m_best_joint_three !== want.best.joint_three)
                        report_mismatch("best_joint_three", m_best_joint_three,
                                        want.best.joint_three);
                    if (m_best_wrist !== want.best.wrist)
                        report_mismatch("best_wrist", m_best_wrist, want.best.wrist);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[pose_bucket_min_move_select] ERROR");
                $finish;
            end
        end
    end

    initial begin
        // Hold reset, then release; the block clears its counts before taking items
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed items run on the reset weights
        @(posedge aclk);
        // query an empty cell
        queue_req(make_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        // two sets of equal cost from a zero pose: the first one must win
        queue_req(make_req(REQ_INSERT, 0, 0, 0, 10, 0, 0, 0, 0));
        queue_req(make_req(REQ_INSERT, 0, 0, 0, -10, 0, 0, 0, 0));
        queue_req(make_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        // fill the cell with full-width and in-range extremes
        queue_req(make_req(REQ_INSERT, 0, 0, 0, 255, 63, -64, 63, 1));
        queue_req(make_req(REQ_INSERT, 0, 0, 0, -256, -64, 63, -64, 0));
        queue_req(make_req(REQ_INSERT, 0, 0, 0, 180, 45, 45, 45, 1));
        queue_req(make_req(REQ_INSERT, 0, 0, 0, -179, -45, -45, -45, 0));
        // the cell is full now: drop this one
        queue_req(make_req(REQ_INSERT, 0, 0, 0, 1, 1, 1, 1, 1));
        queue_req(make_req(REQ_QUERY, 0, 0, 0, 255, 63, -64, 63, 1));
        queue_req(make_req(REQ_QUERY, 0, 0, 0, -256, -64, 63, -64, 0));
        queue_req(make_req(REQ_QUERY, 0, 0, 0, 170, 40, 40, 40, 1));
        // coordinates off the grid on each axis
        queue_req(make_req(REQ_INSERT, -4, 0, 0, 5, 5, 5, 5, 1));
        queue_req(make_req(REQ_QUERY, 0, -4, 0, 5, 5, 5, 5, 1));
        queue_req(make_req(REQ_QUERY, 0, 0, -4, 5, 5, 5, 5, 1));
        queue_req(make_req(REQ_INSERT, -4, -4, -4, 0, 0, 0, 0, 0));
        // grid corners
        queue_req(make_req(REQ_INSERT, -3, -3, -3, -256, -64, -64, -64, 0));
        queue_req(make_req(REQ_INSERT, 3, 3, 3, 255, 63, 63, 63, 1));
        queue_req(make_req(REQ_QUERY, -3, -3, -3, 255, 63, 63, 63, 1));
        queue_req(make_req(REQ_QUERY, 3, 3, 3, -256, -64, -64, -64, 0));
        queue_req(make_req(REQ_QUERY, 3, -3, 3, 0, 0, 0, 0, 0));
        // sets that differ only in the wrist
        queue_req(make_req(REQ_INSERT, 1, 2, -1, 0, 0, 0, 0, 0));
        queue_req(make_req(REQ_INSERT, 1, 2, -1, 0, 0, 0, 0, 1));
        queue_req(make_req(REQ_QUERY, 1, 2, -1, 0, 0, 0, 0, 1));
        wait_quiet();

        // Heaviest weights, no idling; hold the receiver off so the block backs up
        load_weights('1, '1, '1, '1, '1);
        @(posedge aclk);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        queue_random_items(PHASE_ITEMS);
        hold_off_requests++;
        wait_quiet();

        // Zero weights: every set ties, so the first stored one must come back
        load_weights('0, '0, '0, '0, '0);
        @(posedge aclk);
        sender_idle_pct = 68;
        recv_stall_pct  = 0;
        queue_random_items(PHASE_ITEMS);
        wait_quiet();

        // Random weights, receiver stalls often
        load_weights(W_W'($urandom), W_W'($urandom), W_W'($urandom), W_W'($urandom),
                     W_W'($urandom));
        @(posedge aclk);
        sender_idle_pct = 0;
        recv_stall_pct  = 68;
        queue_random_items(PHASE_ITEMS);
        wait_quiet();

        // Mixed extremes, both sides idle
        load_weights('1, '0, W_W'($urandom), '0, '1);
        @(posedge aclk);
        sender_idle_pct = 34;
        recv_stall_pct  = 34;
        queue_random_items(PHASE_ITEMS);
        wait_quiet();

        // Small yaw and joint-one weights so the wrist and later joints decide more often
        load_weights(W_W'($urandom_range(15)), W_W'($urandom_range(15)),
                     W_W'($urandom_range(255)), W_W'($urandom), W_W'($urandom));
        @(posedge aclk);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        queue_random_items(PHASE_ITEMS);
        wait_quiet();

        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("[pose_bucket_min_move_select] OK");
        else
            $display("[pose_bucket_min_move_select] ERROR");
        $finish;
    end

endmodule

/* pose_bucket_min_move_select.f */
design/pbms_pkg.sv
design/pbms_ram.sv
design/pbms_ctrl.sv
design/pbms_dp.sv
design/pose_bucket_min_move_select.sv
design/pbms_chk.sv
sim/pose_bucket_min_move_select_tb.sv
